// ----- rtl/core/pvc_pkg.sv -----
// Package for the printable varint codec: request and result structs,
// byte constants and the structs passed between the codec's submodules.
// Depends on nothing.
package pvc_pkg;

    localparam logic       FUNC_ENC   = 1'b0;
    localparam logic       FUNC_DEC   = 1'b1;

    localparam logic [7:0] TERM_BYTE  = 8'd96;
    localparam logic [7:0] POS_BASE   = 8'd64;
    localparam logic [7:0] DIGIT_BASE = 8'd32;

    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_OVF  = 2'd1;
    localparam logic [1:0] FAULT_BAD  = 2'd2;

    localparam int ENC_GROUPS = 5;

    typedef struct packed {
        logic               func;
        logic signed [31:0] value;
        logic [7:0]         in_byte;
    } pvc_in_t;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic               last;
        logic [2:0]         enc_length;
        logic signed [31:0] decoded;
        logic               decoded_valid;
        logic [1:0]         fault;
    } pvc_out_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic [2:0] enc_length;
    } enc_beat_t;

    typedef struct packed {
        logic signed [31:0] decoded;
        logic               decoded_valid;
        logic [1:0]         fault;
    } dec_res_t;

endpackage

// ----- rtl/core/pvc_enc.sv -----
// Encoder of the printable varint codec: a magnitude shift register that
// gives up one digit per emitted byte. Depends on pvc_pkg.
module pvc_enc
    import pvc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] value,
    input  logic        advance,
    output logic        busy,
    output enc_beat_t   beat
);

    typedef enum logic [1:0] {
        E_IDLE,
        E_FIRST,
        E_DIGIT
    } enc_state_t;

    enc_state_t  state_reg;
    logic [31:0] mag_reg;
    logic        neg_reg;
    logic [2:0]  len_reg;
    logic [2:0]  rem_reg;

    logic [ENC_GROUPS-1:0] grp_nz;
    logic [2:0]            digit_cnt;
    logic [2:0]            first_len;
    logic                  mag_zero;

    always_comb begin
        for (int i = 0; i < ENC_GROUPS; i++) begin
            grp_nz[i] = ((mag_reg >> (5 + 6 * i)) & 32'h3f) != 32'd0;
        end
        digit_cnt = 3'd0;
        for (int i = 0; i < ENC_GROUPS; i++) begin
            if (grp_nz[i]) begin
                digit_cnt = 3'(i + 1);
            end
        end
        mag_zero  = (mag_reg == 32'd0);
        first_len = mag_zero ? 3'd1 : (digit_cnt + 3'd2);
    end

    always_comb begin
        beat = '0;
        case (state_reg)
            E_FIRST: begin
                beat.enc_length = first_len;
                if (mag_zero) begin
                    beat.out_byte = TERM_BYTE;
                    beat.last     = 1'b1;
                end else begin
                    beat.out_byte = (neg_reg ? DIGIT_BASE : POS_BASE) + {3'b000, mag_reg[4:0]};
                end
            end
            E_DIGIT: begin
                beat.enc_length = len_reg;
                if (rem_reg != 3'd0) begin
                    beat.out_byte = DIGIT_BASE + {2'b00, mag_reg[5:0]};
                end else begin
                    beat.out_byte = TERM_BYTE;
                    beat.last     = 1'b1;
                end
            end
            default: beat = '0;
        endcase
    end

    assign busy = (state_reg != E_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
        end else begin
            case (state_reg)
                E_IDLE: begin
                    if (start) begin
                        mag_reg   <= value[31] ? (32'd0 - value) : value;
                        neg_reg   <= value[31];
                        state_reg <= E_FIRST;
                    end
                end
                E_FIRST: begin
                    if (advance) begin
                        if (mag_zero) begin
                            state_reg <= E_IDLE;
                        end else begin
                            mag_reg   <= mag_reg >> 5;
                            len_reg   <= first_len;
                            rem_reg   <= digit_cnt;
                            state_reg <= E_DIGIT;
                        end
                    end
                end
                E_DIGIT: begin
                    if (advance) begin
                        if (rem_reg != 3'd0) begin
                            mag_reg <= mag_reg >> 6;
                            rem_reg <= rem_reg - 3'd1;
                        end else begin
                            state_reg <= E_IDLE;
                        end
                    end
                end
                default: state_reg <= E_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/core/pvc_dec.sv -----
// Decoder of the printable varint codec: takes one byte per request and
// inserts its six-bit digit into the magnitude lane picked by the digit count.
// Depends on pvc_pkg.
module pvc_dec
    import pvc_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       take,
    input  logic [7:0] in_byte,
    input  logic       emit,
    output logic       pending,
    output dec_res_t   res
);

    localparam int AccW = (VALUE_BITS < 32) ? VALUE_BITS : 32;

    logic [AccW-1:0] acc_reg;
    logic [2:0]      shift_reg;
    logic            neg_reg;
    logic            in_num_reg;
    logic            ovf_reg;
    logic            pend_reg;
    logic            bad_reg;

    logic            is_term;
    logic            is_bad;
    logic [7:0]      digit_full;
    logic [5:0]      digit;
    logic [AccW-1:0] ins;
    logic            lost;
    logic [31:0]     mag32;

    always_comb begin
        is_term    = (in_byte == TERM_BYTE);
        is_bad     = (in_byte < DIGIT_BASE) || (in_byte > TERM_BYTE);
        digit_full = in_byte - DIGIT_BASE;
        digit      = digit_full[5:0];
        ins        = '0;
        for (int p = 5; p < AccW; p++) begin
            ins[p] = (shift_reg == 3'((p - 5) / 6)) && digit[(p - 5) % 6];
        end
        lost = 1'b0;
        for (int j = 0; j < 6; j++) begin
            if (digit[j] && ((shift_reg == 3'd7) ||
                    ((5 + 6 * int'(shift_reg) + j) >= VALUE_BITS))) begin
                lost = 1'b1;
            end
        end
    end

    always_comb begin
        mag32 = 32'(acc_reg);
        res   = '0;
        if (bad_reg) begin
            res.fault = FAULT_BAD;
        end else begin
            res.decoded       = neg_reg ? (32'd0 - mag32) : mag32;
            res.decoded_valid = 1'b1;
            res.fault         = (in_num_reg && ovf_reg) ? FAULT_OVF : FAULT_NONE;
        end
    end

    assign pending = pend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg    <= '0;
            shift_reg  <= 3'd0;
            neg_reg    <= 1'b0;
            in_num_reg <= 1'b0;
            ovf_reg    <= 1'b0;
            pend_reg   <= 1'b0;
            bad_reg    <= 1'b0;
        end else if (emit) begin
            pend_reg   <= 1'b0;
            acc_reg    <= '0;
            shift_reg  <= 3'd0;
            neg_reg    <= 1'b0;
            in_num_reg <= 1'b0;
            ovf_reg    <= 1'b0;
        end else if (take) begin
            if (is_term) begin
                pend_reg <= 1'b1;
                bad_reg  <= 1'b0;
            end else if (is_bad) begin
                pend_reg   <= 1'b1;
                bad_reg    <= 1'b1;
                acc_reg    <= '0;
                shift_reg  <= 3'd0;
                neg_reg    <= 1'b0;
                in_num_reg <= 1'b0;
                ovf_reg    <= 1'b0;
            end else if (!in_num_reg) begin
                in_num_reg <= 1'b1;
                neg_reg    <= (in_byte < POS_BASE);
                acc_reg    <= AccW'(in_byte[4:0]);
                shift_reg  <= 3'd0;
                ovf_reg    <= 1'b0;
            end else begin
                acc_reg <= acc_reg | ins;
                if (lost) begin
                    ovf_reg <= 1'b1;
                end
                if (shift_reg != 3'd7) begin
                    shift_reg <= shift_reg + 3'd1;
                end
            end
        end
    end

endmodule

// ----- rtl/core/printable_varint_codec_unit.sv -----
// Printable varint codec top level: one request channel, one result register.
// An encode request passes through the encoder state register and then the result register,
// then gives one byte per cycle while the result register is free; an encoding is n = 1..7 bytes.
// A decode byte gives no result; an end or bad byte holds off requests until its result is registered.
// Synchronous active-low reset clears the decoder state, idles the encoder and empties the result register.
// Depends on pvc_pkg, pvc_enc and pvc_dec.
module printable_varint_codec_unit
    import pvc_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  pvc_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output pvc_out_t m_data
);

    logic      accept;
    logic      out_free;
    logic      enc_busy;
    enc_beat_t enc_beat;
    logic      dec_pending;
    logic      dec_emit;
    dec_res_t  dec_res;
    logic      m_valid_reg;
    pvc_out_t  m_data_reg;

    assign s_ready  = !enc_busy && !dec_pending;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign dec_emit = out_free && dec_pending;

    pvc_enc u_enc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept && (s_data.func == FUNC_ENC)),
        .value   (s_data.value),
        .advance (out_free),
        .busy    (enc_busy),
        .beat    (enc_beat)
    );

    pvc_dec #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (accept && (s_data.func == FUNC_DEC)),
        .in_byte (s_data.in_byte),
        .emit    (dec_emit),
        .pending (dec_pending),
        .res     (dec_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (enc_busy && out_free) begin
            m_valid_reg              <= 1'b1;
            m_data_reg.out_byte      <= enc_beat.out_byte;
            m_data_reg.last          <= enc_beat.last;
            m_data_reg.enc_length    <= enc_beat.enc_length;
            m_data_reg.decoded       <= '0;
            m_data_reg.decoded_valid <= 1'b0;
            m_data_reg.fault         <= FAULT_NONE;
        end else if (dec_emit) begin
            m_valid_reg              <= 1'b1;
            m_data_reg.out_byte      <= 8'd0;
            m_data_reg.last          <= 1'b1;
            m_data_reg.enc_length    <= 3'd0;
            m_data_reg.decoded       <= dec_res.decoded;
            m_data_reg.decoded_valid <= dec_res.decoded_valid;
            m_data_reg.fault         <= dec_res.fault;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- rtl/core/pvc_checker.sv -----
// Port-level checker for the printable varint codec and its bind statement.
// Depends on pvc_pkg and printable_varint_codec_unit.
module pvc_checker
    import pvc_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input pvc_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input pvc_out_t m_data
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Result changed while stalled.");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.func == FUNC_ENC || s_data.in_byte == TERM_BYTE)
        |=> !s_ready)
        else $error("Request accepted while a result-producing request is in progress.");

    a_dec_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.enc_length == 3'd0 |-> m_data.last && m_data.out_byte == 8'd0)
        else $error("Decode result with bad framing.");

    a_enc_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.enc_length != 3'd0
        |-> !m_data.decoded_valid && m_data.fault == FAULT_NONE)
        else $error("Encode result carries decode fields.");

    a_enc_term: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.enc_length != 3'd0 && m_data.last |-> m_data.out_byte == TERM_BYTE)
        else $error("Last encoded byte is not the end mark.");

endmodule

bind printable_varint_codec_unit pvc_checker u_pvc_checker (.*);
